@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the entity decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The antecedent must be followed by the consequent in the same cycle.
`define XED_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold.
`define XED_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define XED_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define XED_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ design/xed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_pkg
// Types, character constants and entity tables of the XML entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_ENABLE = 1'd1;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 4;

    // Output slots of one command: deferred byte, five held bytes, final byte.
    localparam int SLOTS    = 7;
    localparam int HELD_MAX = 5;

    // Characters that take part in the entities.
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_CAP_A = 8'h41;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Prefix of an entity that is currently held.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_AMP   = 4'd1,
        PH_L     = 4'd2,
        PH_LT    = 4'd3,
        PH_G     = 4'd4,
        PH_GT    = 4'd5,
        PH_A     = 4'd6,
        PH_AM    = 4'd7,
        PH_AMPP  = 4'd8,
        PH_Q     = 4'd9,
        PH_QU    = 4'd10,
        PH_QUO   = 4'd11,
        PH_QUOT  = 4'd12,
        PH_HASH  = 4'd13,
        PH_HASHX = 4'd14
    } phase_t;

    // Outcome of offering one byte to the matcher.
    typedef struct packed {
        logic       hit;
        logic       done;
        phase_t     to;
        logic [7:0] emit;
    } edge_t;

    // One command from front to back: the bytes that one item releases.
    typedef struct packed {
        logic [SLOTS-1:0] mask;
        logic [7:0]       pre_byte;
        logic             pre_last;
        phase_t           rel;
        logic [7:0]       fin_byte;
        logic             fin_last;
    } cmd_t;

    // Transition of the matcher for one byte.
    function automatic edge_t step_edge(phase_t ph, logic [7:0] b, logic nl_en);
        edge_t e;
        e = '{hit: 1'b0, done: 1'b0, to: PH_IDLE, emit: 8'h00};
        unique case (ph)
            PH_IDLE:  if (b == CH_AMP) begin e.hit = 1'b1; e.to = PH_AMP; end
            PH_AMP:
            begin
                priority if (b == CH_L) begin e.hit = 1'b1; e.to = PH_L; end
                else if (b == CH_G) begin e.hit = 1'b1; e.to = PH_G; end
                else if (b == CH_A) begin e.hit = 1'b1; e.to = PH_A; end
                else if (b == CH_Q) begin e.hit = 1'b1; e.to = PH_Q; end
                else if (b == CH_HASH && nl_en) begin e.hit = 1'b1; e.to = PH_HASH; end
                else e.hit = 1'b0;
            end
            PH_L:     if (b == CH_T) begin e.hit = 1'b1; e.to = PH_LT; end
            PH_LT:    if (b == CH_SEMI) begin e.hit = 1'b1; e.done = 1'b1; e.emit = CH_LT; end
            PH_G:     if (b == CH_T) begin e.hit = 1'b1; e.to = PH_GT; end
            PH_GT:    if (b == CH_SEMI) begin e.hit = 1'b1; e.done = 1'b1; e.emit = CH_GT; end
            PH_A:     if (b == CH_M) begin e.hit = 1'b1; e.to = PH_AM; end
            PH_AM:    if (b == CH_P) begin e.hit = 1'b1; e.to = PH_AMPP; end
            PH_AMPP:  if (b == CH_SEMI) begin e.hit = 1'b1; e.done = 1'b1; e.emit = CH_AMP; end
            PH_Q:     if (b == CH_U) begin e.hit = 1'b1; e.to = PH_QU; end
            PH_QU:    if (b == CH_O) begin e.hit = 1'b1; e.to = PH_QUO; end
            PH_QUO:   if (b == CH_T) begin e.hit = 1'b1; e.to = PH_QUOT; end
            PH_QUOT:
            begin
                if (b == CH_SEMI)
                begin
                    e.hit  = 1'b1;
                    e.done = 1'b1;
                    e.emit = CH_QUOTE;
                end
            end
            PH_HASH:  if (b == CH_X && nl_en) begin e.hit = 1'b1; e.to = PH_HASHX; end
            PH_HASHX:
            begin
                if (b == CH_CAP_A && nl_en)
                begin
                    e.hit  = 1'b1;
                    e.done = 1'b1;
                    e.emit = CH_NL;
                end
            end
            default:  e.hit = 1'b0;
        endcase
        return e;
    endfunction

    // Number of bytes held in a phase.
    function automatic logic [2:0] held_len(phase_t ph);
        logic [2:0] n;
        unique case (ph)
            PH_AMP:                                    n = 3'd1;
            PH_L, PH_G, PH_A, PH_Q, PH_HASH:           n = 3'd2;
            PH_LT, PH_GT, PH_AM, PH_QU, PH_HASHX:      n = 3'd3;
            PH_AMPP, PH_QUO:                           n = 3'd4;
            PH_QUOT:                                   n = 3'd5;
            default:                                   n = 3'd0;
        endcase
        return n;
    endfunction

    // One bit for each held byte, lowest bit first.
    function automatic logic [HELD_MAX-1:0] held_mask(phase_t ph);
        logic [HELD_MAX-1:0] m;
        logic [2:0]          n;
        n = held_len(ph);
        for (int i = 0; i < HELD_MAX; i++)
        begin
            m[i] = (3'(i) < n);
        end
        return m;
    endfunction

    // Held byte at a position of a phase's prefix text.
    function automatic logic [7:0] held_char(phase_t ph, logic [2:0] idx);
        logic [7:0] c;
        c = CH_AMP;
        unique case (idx)
            3'd0: c = CH_AMP;
            3'd1:
            begin
                unique case (ph)
                    PH_L, PH_LT:                  c = CH_L;
                    PH_G, PH_GT:                  c = CH_G;
                    PH_A, PH_AM, PH_AMPP:         c = CH_A;
                    PH_Q, PH_QU, PH_QUO, PH_QUOT: c = CH_Q;
                    default:                      c = CH_HASH;
                endcase
            end
            3'd2:
            begin
                unique case (ph)
                    PH_LT, PH_GT:                 c = CH_T;
                    PH_AM, PH_AMPP:               c = CH_M;
                    PH_QU, PH_QUO, PH_QUOT:       c = CH_U;
                    default:                      c = CH_X;
                endcase
            end
            3'd3:    c = (ph == PH_AMPP) ? CH_P : CH_O;
            default: c = CH_T;
        endcase
        return c;
    endfunction

endpackage

@@ design/xed_stream_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for encoded input bytes and decoded output bytes.
// ----------------------------------------------------------------------------

// Encoded text, one byte per item.
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded text, one byte per item.
interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ design/xml_entity_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming decoder for the XML character entities lt, gt, amp, quot and
// the newline sequence &#xA.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte per cycle on enc and gives decoded bytes
// on dec, one per cycle while dec is ready, from a registered output. A byte
// that may start or extend an entity is held and gives no output yet; a byte
// that ends or breaks a match releases up to five bytes. The front matcher
// writes a release command into a four-entry queue and the back sequencer
// sends the released bytes out one by one; the input stalls only while that
// queue is full. Between an item and its decoded bytes lie the queue entry,
// the command register and the output register. When a failed "&quot" match
// is followed by a sixth byte, that byte is sent together with the next
// accepted item.
// Registers: index 0 enables decoding (reset 1), index 1 enables the
// newline sequence (reset 1); write them only while the block is idle.
// ----------------------------------------------------------------------------
module xml_entity_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    xed_in_if.sink                         enc,
    xed_out_if.source                      dec,
    input  logic                           cfg_wr_en,
    input  logic [xed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           cfg_data
);
    import xed_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t q_head;

    // Matcher and configuration.
    xed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc       (enc),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Command queue.
    xed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Output sequencer.
    xed_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .dec         (dec)
    );

endmodule

@@ design/xed_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// xed_front
// Accepts text bytes, runs the entity matcher and issues release commands.
// ----------------------------------------------------------------------------
module xed_front (
    input  logic                           clk,
    input  logic                           rst_n,
    xed_in_if.sink                         enc,
    input  logic                           cfg_wr_en,
    input  logic [xed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           cfg_data,
    input  logic                           q_full,
    output logic                           push,
    output xed_pkg::cmd_t                  cmd
);
    import xed_pkg::*;

    logic       dec_en_reg;
    logic       nl_en_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [7:0] pend_byte_reg;
    logic [7:0] pend_byte_next;
    logic       pend_last_reg;
    logic       pend_last_next;
    logic       accept;
    logic       fin_valid;
    edge_t      e;

    assign enc.ready = ~q_full;
    assign accept    = enc.valid & ~q_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_en_reg <= 1'b1;
            nl_en_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DECODE_ENABLE:  dec_en_reg <= cfg_data;
                REG_NEWLINE_ENABLE: nl_en_reg  <= cfg_data;
                default:            dec_en_reg <= dec_en_reg;
            endcase
        end
    end

    // Matcher decision for the offered byte.
    always_comb
    begin
        e               = step_edge(phase_reg, enc.in_byte, nl_en_reg);
        phase_next      = phase_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_last_next  = pend_last_reg;
        fin_valid       = 1'b0;
        cmd.pre_byte    = pend_byte_reg;
        cmd.pre_last    = pend_last_reg;
        cmd.rel         = PH_IDLE;
        cmd.fin_byte    = enc.in_byte;
        cmd.fin_last    = enc.in_last;
        if (accept)
        begin
            pend_valid_next = 1'b0;
            phase_next      = PH_IDLE;
            if (dec_en_reg && e.hit)
            begin
                priority if (e.done)
                begin
                    fin_valid    = 1'b1;
                    cmd.fin_byte = e.emit;
                end
                else if (!enc.in_last)
                begin
                    phase_next = e.to;
                end
                else
                begin
                    cmd.rel   = phase_reg;
                    fin_valid = 1'b1;
                end
            end
            else
            begin
                cmd.rel = phase_reg;
                priority if (dec_en_reg && enc.in_byte == CH_AMP && !enc.in_last)
                begin
                    phase_next = PH_AMP;
                end
                else if (held_len(phase_reg) >= 3'(HELD_MAX))
                begin
                    // A sixth byte waits for the next item.
                    pend_valid_next = 1'b1;
                    pend_byte_next  = enc.in_byte;
                    pend_last_next  = enc.in_last;
                end
                else
                begin
                    fin_valid = 1'b1;
                end
            end
        end
        cmd.mask = {fin_valid, held_mask(cmd.rel), pend_valid_reg};
        push     = accept & (|cmd.mask);
    end

    // Matcher state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Deferred byte payload.
    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        pend_last_reg <= pend_last_next;
    end

    `XED_ASSERT_IMPLY(a_pend_idle, clk, rst_n, pend_valid_reg, phase_reg == PH_IDLE, "deferred byte while a match is held")
    `XED_ASSERT_IMPLY(a_pend_sent, clk, rst_n, accept && pend_valid_reg, push && cmd.mask[0], "deferred byte not sent with the next item")

endmodule

@@ design/xed_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// xed_queue
// Short command queue that decouples the matcher from the output sequencer.
// ----------------------------------------------------------------------------
module xed_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xed_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output xed_pkg::cmd_t head
);
    import xed_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `XED_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "command pushed into a full queue")
    `XED_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !not_empty, "command popped from an empty queue")

endmodule

@@ design/xed_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// xed_back
// Expands release commands into decoded bytes, one per cycle while dec is
// ready, through a registered output stage.
// ----------------------------------------------------------------------------
module xed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  xed_pkg::cmd_t q_head,
    output logic          pop,
    xed_out_if.source     dec
);
    import xed_pkg::*;

    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [SLOTS-1:0] mask_reg;
    logic [SLOTS-1:0] mask_next;
    logic [SLOTS-1:0] mask_after;
    logic [SLOTS-1:0] lowest;
    logic             adv;
    logic [7:0]       slot_byte;
    logic             slot_last;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    assign dec.valid    = out_valid_reg;
    assign dec.out_byte = out_byte_reg;
    assign dec.out_last = out_last_reg;

    // Pick the next byte of the current command.
    always_comb
    begin
        slot_last = 1'b0;
        priority if (mask_reg[0])
        begin
            slot_byte = cmd_reg.pre_byte;
            slot_last = cmd_reg.pre_last;
        end
        else if (mask_reg[1]) slot_byte = held_char(cmd_reg.rel, 3'd0);
        else if (mask_reg[2]) slot_byte = held_char(cmd_reg.rel, 3'd1);
        else if (mask_reg[3]) slot_byte = held_char(cmd_reg.rel, 3'd2);
        else if (mask_reg[4]) slot_byte = held_char(cmd_reg.rel, 3'd3);
        else if (mask_reg[5]) slot_byte = held_char(cmd_reg.rel, 3'd4);
        else
        begin
            slot_byte = cmd_reg.fin_byte;
            slot_last = cmd_reg.fin_last;
        end
    end

    // Advance through the slots and load the next command when done.
    always_comb
    begin
        adv        = (|mask_reg) && (!out_valid_reg || dec.ready);
        lowest     = mask_reg & (~mask_reg + 1'b1);
        mask_after = adv ? (mask_reg & ~lowest) : mask_reg;
        pop        = q_not_empty && (mask_after == '0);
        mask_next  = pop ? q_head.mask : mask_after;
        cmd_next   = pop ? q_head : cmd_reg;
    end

    // Sequencer and output stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dec.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command and output payload.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (adv)
        begin
            out_byte_reg <= slot_byte;
            out_last_reg <= slot_last;
        end
    end

    `XED_ASSERT_IMPLY(a_cmd_nonempty, clk, rst_n, pop, q_head.mask != '0, "empty command in the queue")

endmodule

@@ verif/tb_xml_entity_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_entity_decoder
// Self-checking bench for the streaming XML entity decoder. A driver feeds
// encoded bytes and register writes from a queue. A monitor decodes every
// accepted item with a local model of the matcher and checks each decoded
// byte, in order, against what that model predicts. Both sides of the stream
// take random pauses. The run goes through all register settings and
// through directed entities, broken prefixes and random noise.
// ----------------------------------------------------------------------------
module tb_xml_entity_decoder;

    import xed_pkg::*;

    localparam int unsigned DIRECTED_ITEMS = 25;
    localparam int unsigned RANDOM_ITEMS   = 370;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned MAX_SHOWN      = 10;

    // One entry of the driver's work list: a text byte or a register write.
    typedef struct {
        logic                 is_cfg;
        logic [7:0]           b;
        logic                 last;
        logic [CFG_IDX_W-1:0] idx;
        logic                 data;
    } stim_t;

    // One decoded byte as the block should deliver it.
    typedef struct {
        logic [7:0] b;
        logic       last;
    } dec_byte_t;

    // Outcome of offering one byte to the entity matcher.
    typedef struct {
        logic       hit;
        logic       done;
        phase_t     nxt;
        logic [7:0] emit;
    } match_t;

    logic clk;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    xed_in_if  enc_if ();
    xed_out_if dec_if ();

    xml_entity_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc       (enc_if),
        .dec       (dec_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stim_t     stim_q[$];
    dec_byte_t decoded_q[$];

    // Local copy of the decoder state and its registers.
    phase_t     held_phase;
    logic       defer_valid;
    logic [7:0] defer_byte;
    logic       defer_last;
    logic       decode_on;
    logic       newline_on;

    int unsigned items_queued;
    int unsigned in_count;
    int unsigned in_seen;
    int unsigned out_count;
    int unsigned out_seen;
    int unsigned cfg_writes;
    int unsigned phase_count;
    int unsigned err_count;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned settle;
    logic        in_quiet;
    logic        out_quiet;

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Each side draws a random wait after each item, with stretches of no waiting.
    function automatic int unsigned draw_wait(inout logic quiet);
        if ($urandom_range(0, 29) == 0)
            quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Text of the entity prefix held in a phase.
    function automatic string prefix_text(phase_t ph);
        case (ph)
            PH_AMP:   return "&";
            PH_L:     return "&l";
            PH_LT:    return "&lt";
            PH_G:     return "&g";
            PH_GT:    return "&gt";
            PH_A:     return "&a";
            PH_AM:    return "&am";
            PH_AMPP:  return "&amp";
            PH_Q:     return "&q";
            PH_QU:    return "&qu";
            PH_QUO:   return "&quo";
            PH_QUOT:  return "&quot";
            PH_HASH:  return "&#";
            PH_HASHX: return "&#x";
            default:  return "";
        endcase
    endfunction

    // Full text of one of the five recognized entities.
    function automatic string entity_text(int unsigned k);
        case (k)
            0:       return "&lt;";
            1:       return "&gt;";
            2:       return "&amp;";
            3:       return "&quot;";
            default: return "&#xA";
        endcase
    endfunction

    // Next step of the matcher from a held phase for one byte.
    function automatic match_t match_next(phase_t ph, logic [7:0] b, logic nl);
        match_t m;
        m = '{hit: 1'b0, done: 1'b0, nxt: PH_IDLE, emit: 8'h00};
        case (ph)
            PH_IDLE:
            begin
                if (b == CH_AMP) m.nxt = PH_AMP;
                m.hit = (b == CH_AMP);
            end
            PH_AMP:
            begin
                m.hit = 1'b1;
                if (b == CH_L) m.nxt = PH_L;
                else if (b == CH_G) m.nxt = PH_G;
                else if (b == CH_A) m.nxt = PH_A;
                else if (b == CH_Q) m.nxt = PH_Q;
                else if (b == CH_HASH && nl) m.nxt = PH_HASH;
                else m.hit = 1'b0;
            end
            PH_L:     begin m.hit = (b == CH_T); m.nxt = PH_LT; end
            PH_G:     begin m.hit = (b == CH_T); m.nxt = PH_GT; end
            PH_A:     begin m.hit = (b == CH_M); m.nxt = PH_AM; end
            PH_AM:    begin m.hit = (b == CH_P); m.nxt = PH_AMPP; end
            PH_Q:     begin m.hit = (b == CH_U); m.nxt = PH_QU; end
            PH_QU:    begin m.hit = (b == CH_O); m.nxt = PH_QUO; end
            PH_QUO:   begin m.hit = (b == CH_T); m.nxt = PH_QUOT; end
            PH_HASH:  begin m.hit = (b == CH_X && nl); m.nxt = PH_HASHX; end
            PH_LT:    begin m.hit = (b == CH_SEMI); m.done = 1'b1; m.emit = CH_LT; end
            PH_GT:    begin m.hit = (b == CH_SEMI); m.done = 1'b1; m.emit = CH_GT; end
            PH_AMPP:  begin m.hit = (b == CH_SEMI); m.done = 1'b1; m.emit = CH_AMP; end
            PH_QUOT:  begin m.hit = (b == CH_SEMI); m.done = 1'b1; m.emit = CH_QUOTE; end
            PH_HASHX:
            begin
                m.hit  = (b == CH_CAP_A && nl);
                m.done = 1'b1;
                m.emit = CH_NL;
            end
            default:  m.hit = 1'b0;
        endcase
        return m;
    endfunction

    // Append one byte to the stream of bytes the block should deliver.
    task automatic note_decoded(input logic [7:0] b, input logic last);
        decoded_q.insert(decoded_q.size(), dec_byte_t'{b: b, last: last});
    endtask

    // Decode one accepted byte and append the bytes it releases.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        match_t m;
        string  held;
        held = prefix_text(held_phase);
        if (defer_valid)
        begin
            note_decoded(defer_byte, defer_last);
            defer_valid = 1'b0;
        end
        m = '{hit: 1'b0, done: 1'b0, nxt: PH_IDLE, emit: 8'h00};
        if (decode_on)
            m = match_next(held_phase, b, newline_on);
        if (m.hit && m.done)
        begin
            note_decoded(m.emit, last);
            held_phase = PH_IDLE;
        end
        else if (m.hit && !last)
        begin
            held_phase = m.nxt;
        end
        else
        begin
            // The match fails or the string ends: the held prefix goes out as is.
            for (int i = 0; i < held.len(); i++)
                note_decoded(held[i], 1'b0);
            held_phase = PH_IDLE;
            if (!m.hit && decode_on && b == CH_AMP && !last)
                held_phase = PH_AMP;
            else if (!m.hit && held.len() >= 5)
            begin
                // Sixth byte of a broken quote entity waits for the next item.
                defer_valid = 1'b1;
                defer_byte  = b;
                defer_last  = last;
            end
            else
                note_decoded(b, last);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        stim_q.insert(stim_q.size(),
                      stim_t'{is_cfg: 1'b0, b: b, last: last, idx: '0, data: 1'b0});
        items_queued++;
    endtask

    task automatic queue_text(input string s, input logic mark_last);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], mark_last && (i == s.len() - 1));
    endtask

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic data);
        stim_q.insert(stim_q.size(),
                      stim_t'{is_cfg: 1'b1, b: 8'h00, last: 1'b0, idx: idx, data: data});
    endtask

    // A string of well-formed entities mixed with broken ones and noise.
    task automatic queue_random_string();
        int unsigned n_tok;
        int unsigned pick;
        string       ent;
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
                queue_text(entity_text($urandom_range(0, 4)), 1'b0);
            else if (pick <= 6)
            begin
                ent = entity_text($urandom_range(0, 4));
                queue_text(ent.substr(0, $urandom_range(0, ent.len() - 2)), 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick <= 8)
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                queue_text("&&", 1'b0);
        end
        stim_q[stim_q.size() - 1].last = 1'b1;
    endtask

    // Known values on every input from time zero, then one reset pulse.
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        enc_if.valid   = 1'b0;
        enc_if.in_byte = 8'h00;
        enc_if.in_last = 1'b0;
        dec_if.ready   = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_DECODE_ENABLE;
        cfg_data     = 1'b0;
        held_phase   = PH_IDLE;
        defer_valid  = 1'b0;
        defer_byte   = 8'h00;
        defer_last   = 1'b0;
        decode_on    = 1'b1;
        newline_on   = 1'b1;
        items_queued = 0;
        in_count     = 0;
        in_seen      = 0;
        out_count    = 0;
        out_seen     = 0;
        cfg_writes   = 0;
        phase_count  = 0;
        err_count    = 0;
        gap_left     = 0;
        stall_left   = 0;
        settle       = 0;
        in_quiet     = 1'b0;
        out_quiet    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: presents the next item or register write at the falling edge.
    always @(negedge clk)
    begin
        logic  nxt_valid;
        logic  nxt_wr;
        stim_t s;
        if (rst_n)
        begin
            nxt_valid = enc_if.valid;
            nxt_wr    = 1'b0;
            if (enc_if.valid && in_count != in_seen)
            begin
                in_seen   = in_count;
                nxt_valid = 1'b0;
                gap_left  = draw_wait(in_quiet);
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stim_q.size() > 0)
                begin
                    if (stim_q[0].is_cfg)
                    begin
                        // Registers change only once all decoded bytes are out.
                        if (decoded_q.size() != 0)
                            settle = 0;
                        else if (settle < SETTLE_CYCLES)
                            settle++;
                        else
                        begin
                            s = stim_q.pop_front();
                            nxt_wr = 1'b1;
                            cfg_index <= s.idx;
                            cfg_data  <= s.data;
                        end
                    end
                    else
                    begin
                        s = stim_q.pop_front();
                        nxt_valid = 1'b1;
                        settle    = 0;
                        enc_if.in_byte <= s.b;
                        enc_if.in_last <= s.last;
                    end
                end
            end
            enc_if.valid <= nxt_valid;
            cfg_wr_en    <= nxt_wr;
        end
    end

    // Receiver: after each decoded byte, holds ready low for a random stall.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_count != out_seen)
            begin
                out_seen   = out_count;
                stall_left = draw_wait(out_quiet);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dec_if.ready <= 1'b0;
            end
            else
                dec_if.ready <= 1'b1;
        end
    end

    // Monitor: predicts on accepted items and checks decoded bytes in order.
    always @(posedge clk)
    begin
        dec_byte_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_DECODE_ENABLE)
                    decode_on = cfg_data;
                else if (cfg_index == REG_NEWLINE_ENABLE)
                    newline_on = cfg_data;
                cfg_writes++;
            end
            if (enc_if.valid && enc_if.ready)
            begin
                decode_byte(enc_if.in_byte, enc_if.in_last);
                in_count++;
            end
            if (dec_if.valid && dec_if.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("unexpected decoded byte %02h last %0b",
                                 dec_if.out_byte, dec_if.out_last);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (dec_if.out_byte !== want.b || dec_if.out_last !== want.last)
                    begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display({"decoded byte %0d: expected %02h last %0b, ",
                                      "got %02h last %0b"},
                                     out_count, want.b, want.last,
                                     dec_if.out_byte, dec_if.out_last);
                    end
                end
                out_count++;
            end
        end
    end

    // Stimulus: directed entities first, then phases of random strings.
    initial
    begin : stimulus
        logic        want_dec;
        logic        want_nl;
        int unsigned n_str;
        string       ent;
        // Every entity, the newline sequence and the byte extremes.
        queue_text("&lt;&gt;&amp;&quot;", 1'b1);
        queue_text("&#xA", 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        while (items_queued < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            case (phase_count)
                0:       begin want_dec = 1'b1; want_nl = 1'b1; end
                1:       begin want_dec = 1'b1; want_nl = 1'b0; end
                2:       begin want_dec = 1'b0; want_nl = 1'b1; end
                3:       begin want_dec = 1'b0; want_nl = 1'b0; end
                default:
                begin
                    want_dec = ($urandom_range(0, 3) != 0);
                    want_nl  = 1'($urandom_range(0, 1));
                end
            endcase
            queue_cfg(REG_DECODE_ENABLE, want_dec);
            queue_cfg(REG_NEWLINE_ENABLE, want_nl);
            // A broken quote entity defers its sixth byte; a broken one
            // followed by an ampersand starts a new match.
            if (phase_count == 0)
            begin
                queue_text("&quot!", 1'b1);
                queue_text("&quot&lt;", 1'b1);
            end
            // With the newline sequence disabled it must come out unchanged.
            if (phase_count == 1)
                queue_text("&#xA", 1'b1);
            n_str = $urandom_range(3, 7);
            for (int i = 0; i < n_str; i++)
                queue_random_string();
            // Sometimes leave a partial entity held across the register change.
            if (phase_count == 1)
                queue_text("&am", 1'b0);
            else if ($urandom_range(0, 3) == 0)
            begin
                ent = entity_text($urandom_range(0, 4));
                queue_text(ent.substr(0, $urandom_range(0, ent.len() - 2)), 1'b0);
            end
            phase_count++;
        end

        // Wait for the work list to empty and every decoded byte to arrive.
        @(negedge clk);
        while (stim_q.size() != 0 || enc_if.valid)
            @(negedge clk);
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d encoded bytes over %0d register settings (%0d writes).",
                 in_count, phase_count, cfg_writes);
        $display("Checked %0d decoded bytes, %0d mismatches.", out_count, err_count);
        if (err_count == 0 && decoded_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
